// ===== sv/fspc_pkg.sv =====
package fspc_pkg;

	localparam int unsigned REGISTER_COUNT_DEFAULT = 32;
	localparam int unsigned STAGE_COUNT_DEFAULT = 5;
	localparam logic [31:0] PC_STEP = 32'd4;

	typedef enum logic [3:0] {
		OP_NOP   = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_LOAD  = 4'd3,
		OP_STORE = 4'd4,
		OP_BR    = 4'd5,
		OP_BREQ  = 4'd6,
		OP_BRNEQ = 4'd7,
		OP_HALT  = 4'd8
	} opcode_t;

	localparam logic CFG_FORWARD_ENABLE = 1'b0;
	localparam logic CFG_SPLIT_REGISTER_FILE = 1'b1;

	typedef struct packed {
		logic [3:0]  inst_opcode;
		logic [4:0]  inst_src1;
		logic [31:0] inst_src2;
		logic        inst_src2_is_imm;
		logic [4:0]  inst_dst;
		logic [31:0] load_data;
		logic        load_ready;
	} in_item_t;

	typedef struct packed {
		logic [31:0] next_fetch_address;
		logic [31:0] data_address;
		logic        data_read;
		logic        data_write;
		logic [31:0] data_write_value;
		logic [31:0] program_counter;
	} out_item_t;

	// One stage register: the instruction fields and its latched operands.
	typedef struct packed {
		logic [3:0]  op;
		logic [4:0]  s1;
		logic [31:0] s2;
		logic        imm;
		logic [4:0]  dst;
		logic [31:0] v1;
		logic [31:0] v2;
	} stage_t;

	function automatic logic writes_reg(input logic [3:0] op);
		return op == OP_ADD || op == OP_SUB || op == OP_LOAD;
	endfunction

	function automatic logic s1_hit(input stage_t c, input stage_t o);
		return c.s1 == o.dst && c.s1 != 5'd0;
	endfunction

	function automatic logic s2_hit(input stage_t c, input stage_t o);
		return !c.imm && c.s2 == {27'd0, o.dst} && c.s2 != 32'd0;
	endfunction

	function automatic logic d_hit(input stage_t c, input stage_t o);
		return c.dst == o.dst && c.dst != 5'd0;
	endfunction

	function automatic logic any_hit(input stage_t c, input stage_t o);
		return s1_hit(c, o) || s2_hit(c, o) || (!writes_reg(c.op) && d_hit(c, o));
	endfunction

endpackage

// ===== sv/five_stage_pipeline_core.sv =====
// Five-stage core stepped once per accepted item: every item is one core clock tick.
// Latency: the result for an item is registered and offered the cycle after acceptance.
// Throughput: one item per cycle; a new item is taken while the last result waits, as
// long as the output register is free or is being emptied in the same cycle.
// Reset (arst_n low) clears pc, register file, stage registers, branch and load flags,
// configuration and the output register; the first item only primes fetch.
module five_stage_pipeline_core #(
	parameter int unsigned REGISTER_COUNT = fspc_pkg::REGISTER_COUNT_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  fspc_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output fspc_pkg::out_item_t  out_item,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic                 cfg_data
);
	localparam int ID = 1, EX = 2, MEM = 3, WB = 4;

	logic forward_q, split_q;
	logic [31:0] pc_q, btarget_q;
	logic bvalid_q, lwait_q, primed_q;
	fspc_pkg::stage_t st_q [5];
	logic [31:0] res_q [5];
	logic [31:0] spc_q [5];
	// Execute result computed before a load wait; it lands once the wait ends.
	logic [31:0] exres_q;

	fspc_pkg::stage_t nst [5];
	logic [31:0] nres [5];
	logic [31:0] nspc [5];
	logic [31:0] npc, nbt;
	logic nbv, nlw;
	logic [31:0] nexres;

	logic accept;
	logic [31:0] raddr [4];
	logic [31:0] rdata [4];
	logic rf_we;
	logic [4:0] rf_waddr;
	logic [31:0] rf_wdata;
	fspc_pkg::out_item_t nout;

	assign in_stall = out_valid && out_stall;
	assign accept = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_q <= 1'b0;
			split_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == fspc_pkg::CFG_FORWARD_ENABLE) forward_q <= cfg_data;
			else split_q <= cfg_data;
		end
	end

	fspc_regfile #(.REGISTER_COUNT(REGISTER_COUNT)) u_rf (
		.clk(clk), .arst_n(arst_n), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// Register file write: memory stage in split mode, writeback otherwise.
	always_comb begin
		if (split_q) begin
			rf_we = !lwait_q && fspc_pkg::writes_reg(st_q[MEM].op);
			rf_waddr = st_q[MEM].dst;
			rf_wdata = res_q[MEM];
		end else begin
			rf_we = fspc_pkg::writes_reg(st_q[WB].op);
			rf_waddr = st_q[WB].dst;
			rf_wdata = res_q[WB];
		end
		rf_we = rf_we && accept && primed_q;
	end

	// Values seen after the write of this tick (split mode forwards to decode).
	function automatic logic [31:0] rd_after(input logic [31:0] a, input logic [31:0] v);
		if (rf_we && a == {27'd0, rf_waddr} && rf_waddr != 5'd0 &&
				{27'd0, rf_waddr} < REGISTER_COUNT) return rf_wdata;
		return v;
	endfunction

	// Next-state logic for one tick.
	always_comb begin
		fspc_pkg::stage_t d, f, ex;
		logic [31:0] a, b, c, r, adr, rdst;
		logic stall, hz, flush;
		logic [3:0] mop, pop;
		for (int i = 0; i < 5; i++) begin
			nst[i] = st_q[i];
			nres[i] = res_q[i];
			nspc[i] = spc_q[i];
		end
		npc = pc_q;
		nbt = btarget_q;
		nbv = bvalid_q;
		nlw = lwait_q;
		nexres = exres_q;
		flush = 1'b0;
		stall = 1'b0;
		f = '0;
		f.op = in_item.inst_opcode;
		f.s1 = in_item.inst_src1;
		f.s2 = in_item.inst_src2;
		f.imm = in_item.inst_src2_is_imm;
		f.dst = in_item.inst_dst;
		d = st_q[ID];
		ex = st_q[EX];
		// decode source: the fetched stage if it advances, else the held one
		raddr[0] = {27'd0, st_q[0].s1};
		raddr[1] = st_q[0].s2;
		raddr[2] = {27'd0, d.dst};
		raddr[3] = {27'd0, st_q[MEM].dst};
		a = d.v1;
		b = d.v2;
		c = rd_after(raddr[2], rdata[2]);
		r = '0;
		mop = '0;
		rdst = '0;
		adr = '0;
		hz = 1'b0;

		if (!primed_q) begin
			nst[0] = f;
			nspc[0] = '0;
		end else begin
			nres[EX] = exres_q;
			// writeback
			if (!split_q) nres[WB] = res_q[MEM];
			if (!lwait_q) nst[WB] = st_q[MEM];
			else begin
				nst[WB] = '0;
				nres[WB] = '0;
			end
			if (!lwait_q) begin
				if (forward_q)
					hz = ex.op == fspc_pkg::OP_LOAD && fspc_pkg::any_hit(d, ex);
				else if (d.op != fspc_pkg::OP_NOP)
					hz = (fspc_pkg::writes_reg(ex.op) && fspc_pkg::any_hit(d, ex)) ||
						(fspc_pkg::writes_reg(st_q[MEM].op) && fspc_pkg::any_hit(d, st_q[MEM])) ||
						(!split_q && fspc_pkg::writes_reg(st_q[WB].op) &&
						fspc_pkg::any_hit(d, st_q[WB]));
				stall = !bvalid_q && hz;
			end
			if (!lwait_q && !stall) begin
				npc = bvalid_q ? btarget_q : pc_q + fspc_pkg::PC_STEP;
				nst[0] = f;
				nspc[0] = npc;
				if (bvalid_q) begin
					flush = 1'b1;
					nbv = 1'b0;
					for (int i = ID; i <= MEM; i++) begin
						nst[i] = '0;
						nres[i] = '0;
					end
				end else begin
					// decode takes the fetched instruction
					nst[ID] = st_q[0];
					nspc[ID] = spc_q[0];
					nst[ID].v1 = (st_q[0].s1 < REGISTER_COUNT) ? rd_after(raddr[0], rdata[0]) : '0;
					nst[ID].v2 = st_q[0].imm ? st_q[0].s2 : rd_after(raddr[1], rdata[1]);
					// execute
					nst[EX] = d;
					if (forward_q && d.op != fspc_pkg::OP_NOP) begin
						if (fspc_pkg::s1_hit(d, st_q[MEM]) && fspc_pkg::writes_reg(st_q[MEM].op))
							a = res_q[MEM];
						if (fspc_pkg::s2_hit(d, st_q[MEM]) && fspc_pkg::writes_reg(st_q[MEM].op))
							b = res_q[MEM];
						if (fspc_pkg::d_hit(d, st_q[MEM]) && d.op == fspc_pkg::OP_STORE)
							c = res_q[MEM];
						if (fspc_pkg::s1_hit(d, ex) && fspc_pkg::writes_reg(ex.op)) a = res_q[EX];
						if (fspc_pkg::s2_hit(d, ex) && fspc_pkg::writes_reg(ex.op)) b = res_q[EX];
						if (fspc_pkg::d_hit(d, ex) && d.op == fspc_pkg::OP_STORE) c = res_q[EX];
					end
					nst[EX].v1 = a;
					nst[EX].v2 = b;
					case (d.op)
						fspc_pkg::OP_ADD, fspc_pkg::OP_LOAD: r = a + b;
						fspc_pkg::OP_SUB: r = a - b;
						fspc_pkg::OP_STORE: r = b + c;
						fspc_pkg::OP_BREQ: r = {31'd0, a == b};
						fspc_pkg::OP_BRNEQ: r = {31'd0, a != b};
						default: r = '0;
					endcase
					nres[EX] = r;
					nspc[EX] = spc_q[ID];
				end
			end else if (stall) begin
				nst[EX] = '0;
				nres[EX] = '0;
			end
			// held decode re-reads its operands (register file may have been written)
			if (lwait_q || stall) begin
				raddr[0] = {27'd0, d.s1};
				raddr[1] = d.s2;
				nst[ID].v1 = (d.s1 < REGISTER_COUNT) ? rd_after(raddr[0], rdata[0]) : '0;
				nst[ID].v2 = d.imm ? d.s2 : rd_after(raddr[1], rdata[1]);
			end
			// memory stage
			if (!flush) begin
				adr = res_q[EX];
				if (!lwait_q) nst[MEM] = st_q[EX];
				mop = nst[MEM].op;
				raddr[3] = {27'd0, nst[MEM].dst};
				rdst = rd_after(raddr[3], rdata[3]);
				if (mop == fspc_pkg::OP_LOAD) begin
					nlw = !in_item.load_ready;
					if (in_item.load_ready) nres[MEM] = in_item.load_data;
				end else if (mop == fspc_pkg::OP_STORE) begin
				end else if (((mop == fspc_pkg::OP_BREQ || mop == fspc_pkg::OP_BRNEQ) &&
						adr != 32'd0) || mop == fspc_pkg::OP_BR) begin
					nbt = spc_q[EX] + fspc_pkg::PC_STEP + rdst;
					nbv = 1'b1;
				end else begin
					nres[MEM] = adr;
				end
			end
			// While a load waits the execute result is kept aside and the old one stays.
			nexres = nres[EX];
			if (nlw) nres[EX] = res_q[EX];
		end
		// predicted memory access of the next tick
		pop = '0;
		if (nlw) pop = nst[MEM].op;
		else if (!nbv) pop = nst[EX].op;
		nout.data_read = pop == fspc_pkg::OP_LOAD;
		nout.data_write = pop == fspc_pkg::OP_STORE;
		nout.data_address = (nout.data_read || nout.data_write) ? nres[EX] : '0;
		nout.data_write_value = nout.data_write ? nst[EX].v1 : '0;
		nout.next_fetch_address = nbv ? nbt : npc + fspc_pkg::PC_STEP;
		nout.program_counter = npc;
	end

	// Core state advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			btarget_q <= '0;
			bvalid_q <= 1'b0;
			lwait_q <= 1'b0;
			primed_q <= 1'b0;
			exres_q <= '0;
			for (int i = 0; i < 5; i++) begin
				st_q[i] <= '0;
				res_q[i] <= '0;
				spc_q[i] <= '0;
			end
		end else if (accept) begin
			pc_q <= npc;
			btarget_q <= nbt;
			bvalid_q <= nbv;
			lwait_q <= nlw;
			primed_q <= 1'b1;
			exres_q <= nexres;
			for (int i = 0; i < 5; i++) begin
				st_q[i] <= nst[i];
				res_q[i] <= nres[i];
				spc_q[i] <= nspc[i];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			out_item <= '0;
		end else begin
			if (accept) begin
				out_valid <= 1'b1;
				out_item <= nout;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// A waiting load always sits in the memory stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		lwait_q |-> st_q[MEM].op == fspc_pkg::OP_LOAD) else $error("load wait without load");
	// A branch target is never pending across a load wait.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(bvalid_q && lwait_q)) else $error("branch and load wait together");
	// An accepted item always produces a result next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid) else $error("result missing");
endmodule

// ===== sv/fspc_regfile.sv =====
// Register file with register 0 held at zero; reads outside the file give zero.
module fspc_regfile #(
	parameter int unsigned REGISTER_COUNT = fspc_pkg::REGISTER_COUNT_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [4:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [31:0] raddr [4],
	output logic [31:0] rdata [4]
);
	localparam int unsigned AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

	logic [31:0] regs_q [REGISTER_COUNT];
	logic [31:0] widx;

	assign widx = {27'd0, waddr};

	// Write port; register 0 and out-of-range numbers are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REGISTER_COUNT; i++) regs_q[i] <= '0;
		end else if (we && waddr != 5'd0 && widx < REGISTER_COUNT) begin
			regs_q[widx[AW-1:0]] <= wdata;
		end
	end

	// Four read ports.
	always_comb begin
		for (int p = 0; p < 4; p++) begin
			if (raddr[p] < REGISTER_COUNT) rdata[p] = regs_q[raddr[p][AW-1:0]];
			else rdata[p] = '0;
		end
	end
endmodule
